FILE: hdl/narp_pkg.sv
// Shared constants, types and tables of the note arpeggiator.
package narp_pkg;

	localparam int NOTE_SLOTS = 3;
	localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_SLOTS - 1);

	localparam int WALK_TRIES = 3;
	localparam int TRY_W = $clog2(WALK_TRIES);

	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	localparam int NOTE_W = 7;
	localparam int KIND_W = 2;
	localparam int CFG_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int RES_SUM_W = $clog2(LFSR_W * (NOTE_SLOTS - 1) + 1);
	localparam int MOD_TBL_N = 1 << RES_SUM_W;

	typedef logic [IDX_W-1:0] res_tbl_t [LFSR_W];
	typedef logic [IDX_W-1:0] mod_tbl_t [MOD_TBL_N];

	function automatic res_tbl_t build_res_tbl();
		res_tbl_t t;
		int r;
		r = 1 % NOTE_SLOTS;
		for (int b = 0; b < LFSR_W; b++) begin
			t[b] = IDX_W'(r);
			r = (r * 2) % NOTE_SLOTS;
		end
		return t;
	endfunction

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t t;
		for (int i = 0; i < MOD_TBL_N; i++) begin
			t[i] = IDX_W'(i % NOTE_SLOTS);
		end
		return t;
	endfunction

	// Residue of each LFSR bit weight, and the final reduction of their sum.
	localparam res_tbl_t BIT_RES = build_res_tbl();
	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 2'd0,
		REG_SPEED  = 2'd1,
		REG_ORDER  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ORD_UP     = 2'd0,
		ORD_DOWN   = 2'd1,
		ORD_UPDOWN = 2'd2,
		ORD_RANDOM = 2'd3
	} order_t;

	localparam logic ENABLE_RST = 1'b0;
	localparam logic [KIND_W-1:0] SPEED_RST = 2'd1;
	localparam order_t ORDER_RST = ORD_UP;

	typedef enum logic {
		CMD_CAPTURE = 1'b0,
		CMD_STEP    = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [NOTE_W-1:0] note;
		logic busy;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_EMIT
	} back_state_t;

endpackage

FILE: hdl/note_arpeggiator.sv
// Top level of the note arpeggiator: front end, command queue and walk engine.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  mode, note_in, tick_kind, step_has_note_on
//   result    out        out_valid / out_stall note_out
//   config    in         cfg_we               cfg_index, cfg_data
//
// The front end takes one input beat per cycle while in_stall is low and drops ticks that do not step.
// A capture is handled by the walk engine as it is popped; a stepping tick starts a walk that
// tries one to three slots and, on a hit for a tick without a held note-on, loads the result.
// Two commands queue behind the front end register before in_stall rises.
// Reset empties all slots and the queue; no clearing pass is needed.
// A stalled result holds in its output register while the walk engine waits.
module note_arpeggiator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [narp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [narp_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [narp_pkg::NOTE_W-1:0]      note_in,
	input  logic [narp_pkg::KIND_W-1:0]      tick_kind,
	input  logic                             step_has_note_on,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [narp_pkg::NOTE_W-1:0]      note_out
);
	import narp_pkg::*;

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    pop_cmd;
	order_t  order;

	narp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.note_in          (note_in),
		.tick_kind        (tick_kind),
		.step_has_note_on (step_has_note_on),
		.q_stat           (q_stat),
		.push             (push),
		.push_cmd         (push_cmd),
		.order            (order)
	);

	narp_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	narp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.note_out  (note_out)
	);

endmodule

FILE: hdl/narp_front.sv
// Front end: configuration registers, input beat intake and classification.
module narp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [narp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [narp_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [narp_pkg::NOTE_W-1:0]      note_in,
	input  logic [narp_pkg::KIND_W-1:0]      tick_kind,
	input  logic                             step_has_note_on,
	input  narp_pkg::q_stat_t                q_stat,
	output logic                             push,
	output narp_pkg::cmd_t                   push_cmd,
	output narp_pkg::order_t                 order
);
	import narp_pkg::*;

	logic               enable_q;
	logic [KIND_W-1:0]  speed_q;
	order_t             order_q;
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               accept;
	logic               keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			speed_q  <= SPEED_RST;
			order_q  <= ORDER_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_SPEED:  speed_q  <= cfg_data;
				REG_ORDER:  order_q  <= order_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Ticks of another kind, or any tick while disabled, are dropped here.
	assign keep     = !mode || (enable_q && (tick_kind == speed_q));
	assign in_stall = valid_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind <= mode ? CMD_STEP : CMD_CAPTURE;
			cmd_s1.note <= note_in;
			cmd_s1.busy <= step_has_note_on;
		end
	end

	assign push_cmd = cmd_s1;
	assign order    = order_q;

endmodule

FILE: hdl/narp_cmd_queue.sv
// Short command queue between the front end and the walk engine.
module narp_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  narp_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output narp_pkg::cmd_t    pop_cmd,
	output narp_pkg::q_stat_t q_stat
);
	import narp_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign pop_cmd      = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

FILE: hdl/narp_back.sv
// Walk engine: note slot row, walk state, random source and result register.
module narp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  narp_pkg::order_t              order,
	input  narp_pkg::q_stat_t             q_stat,
	input  narp_pkg::cmd_t                pop_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [narp_pkg::NOTE_W-1:0]   note_out
);
	import narp_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	logic               slot_vld_q  [NOTE_SLOTS];
	logic [NOTE_W-1:0]  slot_note_q [NOTE_SLOTS];
	logic [IDX_W-1:0]   idx_q;
	logic               up_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [TRY_W-1:0]   try_q;
	logic               busy_q;
	logic [NOTE_W-1:0]  hold_note_q;
	logic               out_valid_q;
	logic [NOTE_W-1:0]  out_note_q;

	logic [LFSR_W-1:0]  lfsr_n;
	logic [IDX_W-1:0]   idx_n;
	logic               up_n;
	logic [IDX_W-1:0]   sel;
	logic               hit;
	logic               match;
	logic               do_capture;
	logic               do_try;
	logic               load_out;

	function automatic logic [IDX_W-1:0] lfsr_mod(input logic [LFSR_W-1:0] v);
		logic [RES_SUM_W-1:0] acc_lo;
		logic [RES_SUM_W-1:0] acc_hi;
		acc_lo = '0;
		acc_hi = '0;
		for (int b = 0; b < LFSR_W / 2; b++) begin
			if (v[b]) begin
				acc_lo = acc_lo + RES_SUM_W'(BIT_RES[b]);
			end
			if (v[b + LFSR_W / 2]) begin
				acc_hi = acc_hi + RES_SUM_W'(BIT_RES[b + LFSR_W / 2]);
			end
		end
		return MOD_TBL[acc_lo + acc_hi];
	endfunction

	// One try of the walk: the slot read and the walk state after it.
	always_comb begin
		lfsr_n = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};
		idx_n  = idx_q;
		up_n   = up_q;
		sel    = idx_q;
		case (order)
			ORD_UP: begin
				idx_n = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
			end
			ORD_DOWN: begin
				idx_n = (idx_q == '0) ? LAST_IDX : idx_q - IDX_W'(1);
			end
			ORD_UPDOWN: begin
				if (up_q) begin
					if (idx_q == LAST_IDX) begin
						up_n = 1'b0;
					end else begin
						idx_n = idx_q + IDX_W'(1);
					end
				end else begin
					if (idx_q == '0) begin
						up_n = 1'b1;
					end else begin
						idx_n = idx_q - IDX_W'(1);
					end
				end
			end
			ORD_RANDOM: begin
				sel = lfsr_mod(lfsr_n);
			end
			default: ;
		endcase
		hit = slot_vld_q[sel];
	end

	always_comb begin
		match = 1'b0;
		for (int i = 0; i < NOTE_SLOTS; i++) begin
			if (slot_vld_q[i] && (slot_note_q[i] == pop_cmd.note)) begin
				match = 1'b1;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		do_capture = 1'b0;
		do_try     = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (pop_cmd.kind == CMD_STEP) begin
						state_d = B_WALK;
					end else begin
						do_capture = 1'b1;
					end
				end
			end
			B_WALK: begin
				do_try = 1'b1;
				if (hit) begin
					state_d = busy_q ? B_IDLE : B_EMIT;
				end else if (try_q == TRY_W'(WALK_TRIES - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			up_q        <= 1'b1;
			lfsr_q      <= LFSR_SEED;
			try_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NOTE_SLOTS; i++) begin
				slot_vld_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				try_q  <= '0;
				busy_q <= pop_cmd.busy;
			end
			if (do_try) begin
				try_q <= try_q + TRY_W'(1);
				idx_q <= idx_n;
				up_q  <= up_n;
				if (order == ORD_RANDOM) begin
					lfsr_q <= lfsr_n;
				end
			end
			if (do_capture && !match) begin
				for (int i = 0; i < NOTE_SLOTS - 1; i++) begin
					slot_vld_q[i] <= slot_vld_q[i + 1];
				end
				slot_vld_q[NOTE_SLOTS - 1] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_capture && !match) begin
			for (int i = 0; i < NOTE_SLOTS - 1; i++) begin
				slot_note_q[i] <= slot_note_q[i + 1];
			end
			slot_note_q[NOTE_SLOTS - 1] <= pop_cmd.note;
		end
		if (do_try && hit) begin
			hold_note_q <= slot_note_q[sel];
		end
		if (load_out) begin
			out_note_q <= hold_note_q;
		end
	end

	assign out_valid = out_valid_q;
	assign note_out  = out_note_q;

endmodule

FILE: hdl/narp_checker.sv
// Port-level checks of the note arpeggiator and their binding to the top level.
module narp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [narp_pkg::NOTE_W-1:0]    note_out
);

	// A result beat that is stalled stays offered with the same note.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(note_out))
		else $error("stalled result beat changed or vanished");

	// Reset holds the result channel empty.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat offered during reset");

	// The input side only backs up right after it has taken a beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall rose without a preceding input beat");

endmodule

bind note_arpeggiator narp_checker u_narp_checker (.*);

FILE: sim/note_arpeggiator_test.sv
// Self-checking testbench for the note arpeggiator: directed rows, then random phases.
`timescale 1ns / 100ps

module note_arpeggiator_test;
	import narp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_CYCLES = 32;
	localparam int END_WAIT = 5000;
	localparam int NUM_ROWS = 34;

	typedef struct packed {
		cmd_kind_t mode;
		logic [NOTE_W-1:0] note;
		logic [KIND_W-1:0] kind;
		logic busy;
	} note_event_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_BEAT
	} row_op_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_SILENT,
		CHK_NOTE
	} row_check_t;

	typedef struct packed {
		row_op_t op;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0] reg_val;
		cmd_kind_t mode;
		logic [NOTE_W-1:0] note;
		logic [KIND_W-1:0] kind;
		logic busy;
		row_check_t check;
		logic [NOTE_W-1:0] want;
	} plan_row_t;

	localparam plan_row_t DIRECTED [NUM_ROWS] = '{
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'h55, 2'd1, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_WRITE, REG_ENABLE, 2'd1, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'h2A, 2'd1, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_WRITE, REG_ENABLE, 2'd0, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_CAPTURE, 7'd0,  2'd3, 1'b1, CHK_SILENT, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_CAPTURE, 7'd127, 2'd0, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_CAPTURE, 7'd127, 2'd2, 1'b1, CHK_SILENT, 7'd0},
		'{ROW_WRITE, REG_ENABLE, 2'd1, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd0, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd127, 2'd1, 1'b0, CHK_NOTE,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b1, CHK_SILENT, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_WRITE, REG_SPARE,  2'd0, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_WRITE, REG_ORDER,  ORD_DOWN, CMD_CAPTURE, 7'd0, 2'd0, 1'b0, CHK_MODEL, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_CAPTURE, 7'h55, 2'd1, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_CAPTURE, 7'h2A, 2'd2, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_WRITE, REG_ORDER,  ORD_UPDOWN, CMD_CAPTURE, 7'd0, 2'd0, 1'b0, CHK_MODEL, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_WRITE, REG_ORDER,  ORD_RANDOM, CMD_CAPTURE, 7'd0, 2'd0, 1'b0, CHK_MODEL, 7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b1, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd1, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_WRITE, REG_SPEED,  2'd3, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd3, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd2, 1'b0, CHK_SILENT, 7'd0},
		'{ROW_WRITE, REG_SPEED,  2'd0, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_WRITE, REG_ENABLE, 2'd0, CMD_CAPTURE, 7'd0,  2'd0, 1'b0, CHK_MODEL,  7'd0},
		'{ROW_BEAT,  REG_ENABLE, 2'd0, CMD_STEP,    7'd0,  2'd0, 1'b0, CHK_SILENT, 7'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [NOTE_W-1:0] note_in;
	logic [KIND_W-1:0] tick_kind;
	logic step_has_note_on;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [NOTE_W-1:0] note_out;

	logic slot_full [NOTE_SLOTS];
	logic [NOTE_W-1:0] slot_note [NOTE_SLOTS];
	int walk_pos;
	bit walk_up;
	logic [LFSR_W-1:0] lfsr;
	logic arp_on;
	logic [KIND_W-1:0] arp_rate;
	order_t arp_walk;

	logic [NOTE_W-1:0] pending_notes [$];
	int mismatch_count = 0;
	int notes_checked = 0;
	int beats_sent = 0;
	int captures_sent = 0;
	int settings_used = 0;
	int stall_run = 0;
	bit quiet = 1'b0;

	note_arpeggiator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.note_in(note_in),
		.tick_kind(tick_kind),
		.step_has_note_on(step_has_note_on),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.note_out(note_out)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// Returns 1 when the beat changes the arpeggiator state.
	function automatic bit predict_note(input note_event_t ev, output bit fires,
			output logic [NOTE_W-1:0] note);
		bit held;
		int idx;
		logic fb;
		fires = 1'b0;
		note = '0;
		if (ev.mode == CMD_CAPTURE) begin
			held = 1'b0;
			for (int i = 0; i < NOTE_SLOTS; i++)
				if (slot_full[i] && slot_note[i] == ev.note)
					held = 1'b1;
			if (held)
				return 1'b0;
			for (int i = 0; i + 1 < NOTE_SLOTS; i++) begin
				slot_full[i] = slot_full[i + 1];
				slot_note[i] = slot_note[i + 1];
			end
			slot_full[NOTE_SLOTS - 1] = 1'b1;
			slot_note[NOTE_SLOTS - 1] = ev.note;
			return 1'b1;
		end
		if (!arp_on || ev.kind != arp_rate)
			return 1'b0;
		for (int t = 0; t < WALK_TRIES; t++) begin
			idx = (walk_pos >= NOTE_SLOTS) ? 0 : walk_pos;
			case (arp_walk)
				ORD_UP: walk_pos = (idx + 1 >= NOTE_SLOTS) ? 0 : idx + 1;
				ORD_DOWN: walk_pos = (idx == 0) ? NOTE_SLOTS - 1 : idx - 1;
				ORD_UPDOWN: begin
					if (walk_up) begin
						if (idx + 1 >= NOTE_SLOTS) begin
							walk_pos = idx;
							walk_up = 1'b0;
						end else begin
							walk_pos = idx + 1;
						end
					end else begin
						if (idx == 0) begin
							walk_pos = 0;
							walk_up = 1'b1;
						end else begin
							walk_pos = idx - 1;
						end
					end
				end
				default: begin
					fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
					lfsr = {fb, lfsr[LFSR_W-1:1]};
					idx = int'(lfsr % NOTE_SLOTS);
				end
			endcase
			if (slot_full[idx]) begin
				if (!ev.busy) begin
					fires = 1'b1;
					note = slot_note[idx];
				end
				return 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// Waits until the block has nothing left in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_notes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE: arp_on = val[0];
			REG_SPEED: arp_rate = val;
			REG_ORDER: arp_walk = order_t'(val);
			default: ;
		endcase
	endtask

	// Drives one input beat and records what it should produce once it is taken.
	task automatic send_beat(input note_event_t ev, input row_check_t check,
			input logic [NOTE_W-1:0] want, output bit active);
		bit fires;
		logic [NOTE_W-1:0] note;
		int gap;
		gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= ev.mode;
		note_in <= ev.note;
		tick_kind <= ev.kind;
		step_has_note_on <= ev.busy;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		active = predict_note(ev, fires, note);
		case (check)
			CHK_MODEL: if (fires) pending_notes.push_back(note);
			CHK_NOTE: pending_notes.push_back(want);
			default: ;
		endcase
		beats_sent++;
		if (ev.mode == CMD_CAPTURE)
			captures_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			notes_checked++;
			if (pending_notes.size() == 0) begin
				$display("%0t: note_out expected none, got %0d", $time, note_out);
				mismatch_count++;
			end else begin
				if (note_out !== pending_notes[0]) begin
					$display("%0t: note_out expected %0d, got %0d", $time,
						pending_notes[0], note_out);
					mismatch_count++;
				end
				void'(pending_notes.pop_front());
			end
		end
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 3) == 0)
				stall_run <= idle_len();
		end
	end

	initial begin
		note_event_t ev;
		plan_row_t row;
		bit active;
		int counted;
		int n;
		int slot;
		int w;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ENABLE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= CMD_CAPTURE;
		note_in <= '0;
		tick_kind <= '0;
		step_has_note_on <= 1'b0;
		for (int i = 0; i < NOTE_SLOTS; i++) begin
			slot_full[i] = 1'b0;
			slot_note[i] = '0;
		end
		walk_pos = 0;
		walk_up = 1'b1;
		lfsr = LFSR_SEED;
		arp_on = ENABLE_RST;
		arp_rate = SPEED_RST;
		arp_walk = ORDER_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.op == ROW_WRITE) begin
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				ev = '{row.mode, row.note, row.kind, row.busy};
				send_beat(ev, row.check, row.want, active);
			end
		end
		settings_used = 7;

		// Random phases: mostly stepping ticks and fresh captures under one setting each.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			write_reg(REG_ENABLE, CFG_W'($urandom_range(0, 7) != 0));
			write_reg(REG_SPEED, CFG_W'($urandom_range(0, 3)));
			write_reg(REG_ORDER, CFG_W'($urandom_range(0, 3)));
			quiet = ($urandom_range(0, 4) == 0);
			settings_used++;
			n = 0;
			while (n < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
				ev.note = NOTE_W'($urandom_range(0, 127));
				ev.kind = KIND_W'($urandom_range(0, 3));
				ev.busy = ($urandom_range(0, 4) == 0);
				w = $urandom_range(0, 99);
				if (w < 35) begin
					ev.mode = CMD_CAPTURE;
					slot = $urandom_range(0, NOTE_SLOTS - 1);
					if ($urandom_range(0, 3) == 0 && slot_full[slot])
						ev.note = slot_note[slot];
				end else begin
					ev.mode = CMD_STEP;
					if (w < 90)
						ev.kind = arp_rate;
				end
				send_beat(ev, CHK_MODEL, '0, active);
				if (active) begin
					n++;
				end
				counted++;
			end
		end

		in_valid <= 1'b0;
		for (w = 0; w < END_WAIT && pending_notes.size() != 0; w++)
			@(posedge clk);
		if (pending_notes.size() != 0) begin
			$display("%0t: note_out expected %0d, got nothing (%0d notes missing)", $time,
				pending_notes[0], pending_notes.size());
			mismatch_count++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d beats (%0d captures) across %0d register settings.",
			beats_sent, captures_sent, settings_used);
		$display("Checked %0d arpeggio notes, %0d mismatches.", notes_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout with %0d notes still expected", $time, pending_notes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
hdl/narp_pkg.sv
hdl/narp_front.sv
hdl/narp_cmd_queue.sv
hdl/narp_back.sv
hdl/note_arpeggiator.sv
hdl/narp_checker.sv
sim/note_arpeggiator_test.sv
